// ===== src/cpr_pkg.sv =====
// shared types and constants for the clock page replacement core
`timescale 1ns / 1ps

package cpr_pkg;

    // fixed field widths
    localparam int PAGE_FIELD_W = 16;
    localparam int SLOT_W       = 4;
    localparam int FAULT_W      = 16;
    localparam int CFG_W        = 5;
    localparam int OUT_TDATA_W  = 40;

    // defaults for the top-level parameters
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_SWEEP,
        S_DONE
    } cpr_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic touch;
        logic fill;
        logic start_sweep;
        logic sweep_clear;
        logic evict;
        logic load_out;
    } cpr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hit_any;
        logic empty_any;
        logic ref_at_hand;
        logic out_free;
    } cpr_sts_t;

endpackage

// ===== src/clock_page_replacement_core.sv =====
// top level of the clock (second chance) page replacement core
`timescale 1ns / 1ps

// Each input item is one page reference; each gives exactly one result item.
// A hit or a fill of an empty frame passes through LOOK and DECIDE to DONE,
// where its result is loaded once the output register is free. A miss with
// every active frame occupied runs the clock hand, which visits one frame per
// cycle until it evicts a frame whose reference bit is clear. The block takes
// one item at a time; the next item is taken in the cycle after the result
// enters the output register, even while it still waits to be taken. The user
// must write frames_in_use via cfg_wen/cfg_wdata only while the block is idle
// (unenforced); 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES.

module clock_page_replacement_core #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [cpr_pkg::CFG_W-1:0]           cfg_wdata,     // frames_in_use
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cpr_pkg::PAGE_FIELD_W-1:0]    s_tdata,       // page
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, frame_slot[3:0], evicted_valid, evicted_page[15:0], fault_count[15:0], pad
    output logic [cpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import cpr_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] frames_reg;
    logic [CMP_W-1:0] frames_ext;
    logic [CMP_W-1:0] n_clamp;
    logic [CNT_W-1:0] n_act;
    cpr_cmd_t         cmd;
    cpr_sts_t         sts;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= CFG_RESET;
        end else if (cfg_wen) begin
            frames_reg <= cfg_wdata;
        end
    end

    // clamp the frame count to 1..MAX_FRAMES
    assign frames_ext = CMP_W'(frames_reg);

    always_comb begin
        priority if (frames_ext == '0) begin
            n_clamp = CMP_W'(1);
        end else if (frames_ext > CMP_W'(MAX_FRAMES)) begin
            n_clamp = CMP_W'(MAX_FRAMES);
        end else begin
            n_clamp = frames_ext;
        end
    end

    assign n_act = n_clamp[CNT_W-1:0];

    cpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpr_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .n_act    (n_act),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/cpr_ctrl.sv =====
// controller state machine for the clock page replacement core
`timescale 1ns / 1ps

module cpr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cpr_pkg::cpr_sts_t sts,
    output cpr_pkg::cpr_cmd_t cmd
);
    import cpr_pkg::*;

    cpr_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_LOOK;
            end
            S_LOOK: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.hit_any || sts.empty_any) state_next = S_DONE;
                else state_next = S_SWEEP;
            end
            S_SWEEP: begin
                if (!sts.ref_at_hand) state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_LOOK: begin
                cmd.look = 1'b1;
            end
            S_DECIDE: begin
                priority if (sts.hit_any) begin
                    cmd.touch = 1'b1;
                end else if (sts.empty_any) begin
                    cmd.fill = 1'b1;
                end else begin
                    cmd.start_sweep = 1'b1;
                end
            end
            S_SWEEP: begin
                cmd.sweep_clear = sts.ref_at_hand;
                cmd.evict       = !sts.ref_at_hand;
            end
            S_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // at most one frame table write per cycle
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.touch, cmd.fill, cmd.sweep_clear, cmd.evict}))
        else $error("more than one frame table write in a cycle");

    // an accepted item always goes on to the lookup
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_LOOK))
        else $error("accepted item did not enter lookup");

endmodule

// ===== src/cpr_datapath.sv =====
// frame table, clock hand, fault counter and result register
`timescale 1ns / 1ps

module cpr_datapath #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF,
    parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cpr_pkg::cpr_cmd_t                   cmd,
    output cpr_pkg::cpr_sts_t                   sts,
    input  logic [CNT_W-1:0]                    n_act,
    input  logic [cpr_pkg::PAGE_FIELD_W-1:0]    s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cpr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import cpr_pkg::*;

    // frame table
    logic [PAGE_BITS-1:0]  page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [MAX_FRAMES-1:0] ref_reg, ref_next;
    logic [MAX_FRAMES-1:0] active_vec;
    logic [MAX_FRAMES-1:0] match_reg, empty_reg;

    // item and working registers
    logic [PAGE_BITS-1:0]  pg_reg;
    logic                  last_reg;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [IDX_W-1:0]      slot_reg;
    logic                  hit_reg;
    logic                  evv_reg;
    logic [PAGE_BITS-1:0]  evp_reg;
    logic [FAULT_W-1:0]    faults_reg, faults_next;

    // result register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    logic [IDX_W-1:0]      hit_idx, empty_idx, wr_idx;
    logic [CNT_W-1:0]      hand_inc;
    logic [IDX_W-1:0]      hand_adv;
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] in_ext, ev_ext;
    logic [IDX_W+SLOT_W-1:0]           slot_ext;

    assign in_ext = {{PAGE_BITS{1'b0}}, s_tdata};

    // frames taking part in lookup and replacement
    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_active
            assign active_vec[gi] = (CNT_W'(gi) < n_act);
        end
    endgenerate

    // lowest matching and lowest empty frame
    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (match_reg[i]) hit_idx = IDX_W'(i);
            if (empty_reg[i]) empty_idx = IDX_W'(i);
        end
    end

    // hand advance, wrapping at the active frame count
    assign hand_inc = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_adv = (hand_inc >= n_act) ? '0 : hand_inc[IDX_W-1:0];

    always_comb begin
        hand_next = hand_reg;
        if (cmd.start_sweep) begin
            hand_next = (CNT_W'(hand_reg) < n_act) ? hand_reg : '0;
        end else if (cmd.sweep_clear || cmd.evict) begin
            hand_next = hand_adv;
        end
    end

    // valid and reference bit updates
    always_comb begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        if (cmd.touch) ref_next[hit_idx] = 1'b1;
        if (cmd.fill) begin
            valid_next[empty_idx] = 1'b1;
            ref_next[empty_idx]   = 1'b0;
        end
        if (cmd.sweep_clear) ref_next[hand_reg] = 1'b0;
        if (cmd.evict) begin
            valid_next[hand_reg] = 1'b1;
            ref_next[hand_reg]   = 1'b0;
        end
    end

    // saturating fault count
    always_comb begin
        faults_next = faults_reg;
        if (!hit_reg && (faults_reg != FAULT_MAX)) faults_next = faults_reg + FAULT_W'(1);
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            ref_reg       <= '0;
            hand_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            hand_reg  <= hand_next;
            if (cmd.load_out) begin
                faults_reg    <= faults_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // page store, one write port
    assign wr_idx = cmd.fill ? empty_idx : hand_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fill || cmd.evict) page_reg[wr_idx] <= pg_reg;
    end

    // item capture, lookup vectors and result fields
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pg_reg   <= in_ext[PAGE_BITS-1:0];
            last_reg <= s_tlast;
        end
        if (cmd.look) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                match_reg[i] <= valid_reg[i] && active_vec[i] && (page_reg[i] == pg_reg);
                empty_reg[i] <= !valid_reg[i] && active_vec[i];
            end
        end
        if (cmd.touch) begin
            hit_reg  <= 1'b1;
            slot_reg <= hit_idx;
            evv_reg  <= 1'b0;
            evp_reg  <= '0;
        end
        if (cmd.fill) begin
            hit_reg  <= 1'b0;
            slot_reg <= empty_idx;
            evv_reg  <= 1'b0;
            evp_reg  <= '0;
        end
        if (cmd.evict) begin
            hit_reg  <= 1'b0;
            slot_reg <= hand_reg;
            evv_reg  <= 1'b1;
            evp_reg  <= page_reg[hand_reg];
        end
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, faults_next, ev_ext[PAGE_FIELD_W-1:0], evv_reg,
                             slot_ext[SLOT_W-1:0], hit_reg};
            out_last_reg <= last_reg;
        end
    end

    assign ev_ext   = {{PAGE_FIELD_W{1'b0}}, evp_reg};
    assign slot_ext = {{SLOT_W{1'b0}}, slot_reg};

    // status to controller
    assign sts.hit_any     = |match_reg;
    assign sts.empty_any   = |empty_reg;
    assign sts.ref_at_hand = ref_reg[hand_reg];
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // the sweep only runs once every active frame is occupied
    a_full_on_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> &(valid_reg | ~active_vec))
        else $error("eviction while an active frame is empty");

    // the hand stays inside the active frames while sweeping
    a_hand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep_clear || cmd.evict) |-> (CNT_W'(hand_reg) < n_act))
        else $error("clock hand outside active frames");

    // fault total never goes down
    a_fault_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (faults_next >= faults_reg))
        else $error("fault count decreased");

endmodule
